// ===== src/wpo_pkg.sv =====
// package: types, codes and constants of the wheel pulse odometry block
package wpo_pkg;

  // default counter width
  localparam int unsigned CountWidthDef = 32;

  // field widths
  localparam int unsigned ActionW = 3;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned SpeedW  = 8;
  localparam int unsigned PprW    = 16;
  localparam int unsigned CircW   = 20;
  localparam int unsigned PowerW  = 20;
  localparam int unsigned Q16W    = 32;
  localparam int unsigned PosW    = 52;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;

  // multiply-divide engine widths
  localparam int unsigned OpW   = 64;
  localparam int unsigned ProdW = 128;
  localparam int unsigned CntW  = 7;

  // 60000 * 65536
  localparam logic [OpW-1:0] RpmScale  = 64'd3932160000;
  localparam logic [OpW-1:0] PosMax    = 64'h0007_FFFF_FFFF_FFFF;
  localparam logic [OpW-1:0] PosMinMag = 64'h0008_0000_0000_0000;
  localparam logic [OpW-1:0] Cap32     = 64'h0000_0000_FFFF_FFFF;
  localparam logic [OpW-1:0] VelMax    = 64'h0000_0000_7FFF_FFFF;
  localparam logic [OpW-1:0] VelMinMag = 64'h0000_0000_8000_0000;
  localparam logic [OpW-1:0] EffScale  = 64'h0000_0001_0000_0000;
  localparam logic [9:0]     Milli     = 10'd1000;

  // register reset values
  localparam logic [PprW-1:0]   PprRst     = 16'd1024;
  localparam logic [CircW-1:0]  CircRst    = 20'd502655;
  localparam logic [PowerW-1:0] PowerRst   = 20'd100000;
  localparam logic [Q16W-1:0]   MinVelRst  = 32'd6554;
  localparam logic [TimeW-1:0]  TimeoutRst = 32'd1000;

  typedef enum logic [ActionW-1:0] {
    ACT_PULSE   = 3'd0,
    ACT_SAMPLE  = 3'd1,
    ACT_READ    = 3'd2,
    ACT_DRIVE   = 3'd3,
    ACT_REFRESH = 3'd4,
    ACT_CHECK   = 3'd5
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PPR     = 3'd0,
    REG_CIRC    = 3'd1,
    REG_POWER   = 3'd2,
    REG_MIN_VEL = 3'd3,
    REG_TIMEOUT = 3'd4
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    OP_POS = 2'd0,
    OP_RPM = 2'd1,
    OP_VEL = 2'd2,
    OP_EFF = 2'd3
  } op_e;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [TimeW-1:0]   now_ms;
    logic [SpeedW-1:0]  speed;
    logic               forward;
  } in_t;

  typedef struct packed {
    logic signed [PosW-1:0] position_um;
    logic [Q16W-1:0]        rpm_q16;
    logic signed [Q16W-1:0] velocity_q16;
    logic [Q16W-1:0]        effort_q16;
    logic                   timed_out;
    logic [SpeedW-1:0]      pwm_duty;
    logic                   pwm_run;
    logic                   brake_on;
    logic                   direction_pin;
  } out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] data;
  } cfg_t;

endpackage

// ===== src/wpo_chan_if.sv =====
// valid/ready channel carrying one payload
interface wpo_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/wheel_pulse_odometry.sv =====
// wheel pulse odometry: pulse counter, sampled position/rpm/velocity/effort, drive and timeout
//
// One request in gives one result out. Pulse, feedback read, set drive, timeout refresh and
// timeout check pass from acceptance through the DONE state into the result register. A sample
// runs the position, rpm and velocity quotients, and the effort quotient when |velocity| is
// nonzero and reaches the minimum, through one shared bit-serial multiply-divide unit: each
// pass is a load, a shift-add multiply and a restoring division. One request is in work at a
// time; the next is taken once the result register is free or being drained. Configuration
// writes are taken in any cycle and apply at once.
module wheel_pulse_odometry #(
  parameter int unsigned COUNT_WIDTH = wpo_pkg::CountWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wpo_chan_if.sink   in_i,
  wpo_chan_if.source out_o,
  wpo_chan_if.sink   cfg_i
);

  localparam int unsigned OpW   = wpo_pkg::OpW;
  localparam int unsigned ProdW = wpo_pkg::ProdW;
  localparam int unsigned CntW  = wpo_pkg::CntW;

  // configuration registers
  logic [wpo_pkg::PprW-1:0]   ppr_q;
  logic [wpo_pkg::CircW-1:0]  circ_q;
  logic [wpo_pkg::PowerW-1:0] power_q;
  logic [wpo_pkg::Q16W-1:0]   min_vel_q;
  logic [wpo_pkg::TimeW-1:0]  timeout_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q     <= wpo_pkg::PprRst;
      circ_q    <= wpo_pkg::CircRst;
      power_q   <= wpo_pkg::PowerRst;
      min_vel_q <= wpo_pkg::MinVelRst;
      timeout_q <= wpo_pkg::TimeoutRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        wpo_pkg::REG_PPR:     ppr_q     <= cfg_i.data.data[wpo_pkg::PprW-1:0];
        wpo_pkg::REG_CIRC:    circ_q    <= cfg_i.data.data[wpo_pkg::CircW-1:0];
        wpo_pkg::REG_POWER:   power_q   <= cfg_i.data.data[wpo_pkg::PowerW-1:0];
        wpo_pkg::REG_MIN_VEL: min_vel_q <= cfg_i.data.data;
        wpo_pkg::REG_TIMEOUT: timeout_q <= cfg_i.data.data;
        default: ;
      endcase
    end
  end

  // state
  wpo_pkg::state_e state_q;
  wpo_pkg::op_e    op_q;
  logic [wpo_pkg::ActionW-1:0] act_q;
  logic                        timed_q;

  logic signed [COUNT_WIDTH-1:0] cnt_q;
  logic signed [COUNT_WIDTH-1:0] prev_cnt_q;
  logic [wpo_pkg::TimeW-1:0]     prev_time_q;
  logic                          sampled_q;
  logic                          reverse_q;
  logic [wpo_pkg::TimeW-1:0]     stamp_q;
  logic [wpo_pkg::PosW-1:0]      held_pos_q;
  logic [wpo_pkg::Q16W-1:0]      held_rpm_q;
  logic [wpo_pkg::Q16W-1:0]      held_vel_q;
  logic [wpo_pkg::Q16W-1:0]      held_eff_q;
  logic [wpo_pkg::SpeedW-1:0]    held_duty_q;

  // sample operands
  logic [OpW-1:0] delta_q;
  logic [OpW-1:0] mag_q;
  logic           neg_q;
  logic [47:0]    den_q;
  logic [31:0]    vm_q;

  // output register
  logic          out_valid_q;
  wpo_pkg::out_t out_q;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign in_i.ready  = (state_q == wpo_pkg::ST_IDLE) && (!out_valid_q || out_o.ready);

  logic accept;
  assign accept = in_i.valid && in_i.ready;

  // counter extremes
  logic signed [COUNT_WIDTH-1:0] cnt_max, cnt_min;
  assign cnt_max = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  assign cnt_min = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  // sample set-up arithmetic
  logic signed [COUNT_WIDTH-1:0] pc_eff;
  logic [wpo_pkg::TimeW-1:0]     pt_eff, dt;
  logic signed [OpW-1:0]         cur_x, prev_x;
  logic [OpW-1:0]                delta_d, mag_d;

  always_comb begin
    pc_eff  = sampled_q ? prev_cnt_q : cnt_q;
    pt_eff  = sampled_q ? prev_time_q : in_i.data.now_ms;
    dt      = in_i.data.now_ms - pt_eff;
    cur_x   = OpW'(cnt_q);
    prev_x  = OpW'(pc_eff);
    delta_d = (cur_x >= prev_x) ? OpW'(cur_x - prev_x) : OpW'(prev_x - cur_x);
    mag_d   = cnt_q[COUNT_WIDTH-1] ? OpW'(-cur_x) : OpW'(cur_x);
  end

  // operand selection for the shared unit
  logic [OpW-1:0] sel_a, sel_b, sel_d, sel_cap;

  always_comb begin
    case (op_q)
      wpo_pkg::OP_POS: begin
        sel_a   = mag_q;
        sel_b   = OpW'(circ_q);
        sel_d   = OpW'(ppr_q);
        sel_cap = neg_q ? wpo_pkg::PosMinMag : wpo_pkg::PosMax;
      end
      wpo_pkg::OP_RPM: begin
        sel_a   = delta_q;
        sel_b   = wpo_pkg::RpmScale;
        sel_d   = OpW'(den_q);
        sel_cap = wpo_pkg::Cap32;
      end
      wpo_pkg::OP_VEL: begin
        sel_a   = delta_q;
        sel_b   = OpW'({circ_q, 16'h0000});
        sel_d   = OpW'(den_q) * OpW'(wpo_pkg::Milli);
        sel_cap = reverse_q ? wpo_pkg::VelMinMag : wpo_pkg::VelMax;
      end
      default: begin
        sel_a   = OpW'(power_q);
        sel_b   = wpo_pkg::EffScale;
        sel_d   = OpW'(vm_q) * OpW'(wpo_pkg::Milli);
        sel_cap = wpo_pkg::Cap32;
      end
    endcase
  end

  // shift-add multiply then restoring divide, one bit per cycle
  logic [ProdW-1:0] acc_q, mcand_q;
  logic [OpW-1:0]   mplier_q, d_q, cap_q, quo_q;
  logic [OpW:0]     rem_q;
  logic             ovf_q;
  logic [CntW-1:0]  step_q;

  logic [OpW:0]   rem_sh, rem_d;
  logic           ge;
  logic [OpW-1:0] quo_d, res;
  logic           ovf_d;

  always_comb begin
    rem_sh = {rem_q[OpW-1:0], acc_q[ProdW-1]};
    ge     = rem_sh >= {1'b0, d_q};
    rem_d  = ge ? (rem_sh - {1'b0, d_q}) : rem_sh;
    quo_d  = {quo_q[OpW-2:0], ge};
    ovf_d  = ovf_q | quo_q[OpW-1];
    if (d_q == '0) begin
      res = '0;
    end else if (ovf_d || (quo_d > cap_q)) begin
      res = cap_q;
    end else begin
      res = quo_d;
    end
  end

  logic [wpo_pkg::PosW-1:0] pos_res;
  assign pos_res = neg_q ? wpo_pkg::PosW'(-res) : res[wpo_pkg::PosW-1:0];

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wpo_pkg::ST_IDLE;
      op_q        <= wpo_pkg::OP_POS;
      act_q       <= '0;
      timed_q     <= 1'b0;
      cnt_q       <= '0;
      prev_cnt_q  <= '0;
      prev_time_q <= '0;
      sampled_q   <= 1'b0;
      reverse_q   <= 1'b0;
      stamp_q     <= '0;
      held_pos_q  <= '0;
      held_rpm_q  <= '0;
      held_vel_q  <= '0;
      held_eff_q  <= '0;
      held_duty_q <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        wpo_pkg::ST_IDLE: begin
          if (accept) begin
            act_q   <= in_i.data.action;
            timed_q <= 1'b0;
            state_q <= wpo_pkg::ST_DONE;
            case (in_i.data.action)
              wpo_pkg::ACT_PULSE: begin
                if (reverse_q) begin
                  cnt_q <= (cnt_q == cnt_min) ? '0 : cnt_q - 1'b1;
                end else begin
                  cnt_q <= (cnt_q == cnt_max) ? '0 : cnt_q + 1'b1;
                end
              end
              wpo_pkg::ACT_SAMPLE: begin
                prev_time_q <= in_i.data.now_ms;
                prev_cnt_q  <= cnt_q;
                sampled_q   <= 1'b1;
                op_q        <= wpo_pkg::OP_POS;
                state_q     <= wpo_pkg::ST_LOAD;
              end
              wpo_pkg::ACT_DRIVE: begin
                reverse_q   <= !in_i.data.forward;
                held_duty_q <= in_i.data.speed;
              end
              wpo_pkg::ACT_REFRESH: begin
                stamp_q <= in_i.data.now_ms;
              end
              wpo_pkg::ACT_CHECK: begin
                if ((in_i.data.now_ms - stamp_q) >= timeout_q) begin
                  stamp_q <= in_i.data.now_ms;
                  timed_q <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        wpo_pkg::ST_LOAD: begin
          step_q  <= '0;
          state_q <= wpo_pkg::ST_MUL;
        end
        wpo_pkg::ST_MUL: begin
          step_q <= step_q + 1'b1;
          if (step_q == CntW'(OpW - 1)) begin
            step_q  <= '0;
            state_q <= wpo_pkg::ST_DIV;
          end
        end
        wpo_pkg::ST_DIV: begin
          step_q <= step_q + 1'b1;
          if (step_q == CntW'(ProdW - 1)) begin
            state_q <= wpo_pkg::ST_LOAD;
            case (op_q)
              wpo_pkg::OP_POS: begin
                held_pos_q <= pos_res;
                op_q       <= wpo_pkg::OP_RPM;
              end
              wpo_pkg::OP_RPM: begin
                held_rpm_q <= res[31:0];
                op_q       <= wpo_pkg::OP_VEL;
              end
              wpo_pkg::OP_VEL: begin
                held_vel_q <= reverse_q ? 32'(-res) : res[31:0];
                if ((res != '0) && (res >= OpW'(min_vel_q))) begin
                  op_q <= wpo_pkg::OP_EFF;
                end else begin
                  state_q <= wpo_pkg::ST_DONE;
                end
              end
              default: begin
                held_eff_q <= res[31:0];
                state_q    <= wpo_pkg::ST_DONE;
              end
            endcase
          end
        end
        wpo_pkg::ST_DONE: begin
          out_valid_q <= 1'b1;
          state_q     <= wpo_pkg::ST_IDLE;
          if (act_q == wpo_pkg::ACT_READ) begin
            held_rpm_q <= '0;
            held_vel_q <= '0;
            held_eff_q <= '0;
          end
        end
        default: state_q <= wpo_pkg::ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept && (in_i.data.action == wpo_pkg::ACT_SAMPLE)) begin
      delta_q <= delta_d;
      mag_q   <= mag_d;
      neg_q   <= cnt_q[COUNT_WIDTH-1];
      den_q   <= ppr_q * dt;
    end
    if ((state_q == wpo_pkg::ST_DIV) && (op_q == wpo_pkg::OP_VEL)) begin
      vm_q <= res[31:0];
    end
    case (state_q)
      wpo_pkg::ST_LOAD: begin
        acc_q    <= '0;
        mcand_q  <= ProdW'(sel_a);
        mplier_q <= sel_b;
        d_q      <= sel_d;
        cap_q    <= sel_cap;
        rem_q    <= '0;
        quo_q    <= '0;
        ovf_q    <= 1'b0;
      end
      wpo_pkg::ST_MUL: begin
        if (mplier_q[0]) begin
          acc_q <= acc_q + mcand_q;
        end
        mcand_q  <= {mcand_q[ProdW-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[OpW-1:1]};
      end
      wpo_pkg::ST_DIV: begin
        acc_q <= {acc_q[ProdW-2:0], 1'b0};
        rem_q <= rem_d;
        quo_q <= quo_d;
        ovf_q <= ovf_d;
      end
      default: ;
    endcase
    // result snapshot
    if (state_q == wpo_pkg::ST_DONE) begin
      out_q.position_um   <= held_pos_q;
      out_q.rpm_q16       <= held_rpm_q;
      out_q.velocity_q16  <= held_vel_q;
      out_q.effort_q16    <= held_eff_q;
      out_q.timed_out     <= timed_q;
      out_q.pwm_duty      <= held_duty_q;
      out_q.pwm_run       <= held_duty_q != '0;
      out_q.brake_on      <= held_duty_q == '0;
      out_q.direction_pin <= !reverse_q;
    end
  end

endmodule
